/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define LSEU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Same check with a caller-supplied message string.
`define LSEU_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/lseu_pkg.sv */
// Shared types, constants and helpers for the logic/shift execute unit.
// No dependencies.
`default_nettype none

package lseu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int IDX_W     = 5;
    localparam int DATA_W    = 32;

    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

    // instruction codes as carried on the cmd port
    typedef enum logic [4:0] {
        CMD_OR      = 5'd0,
        CMD_ZXB     = 5'd1,
        CMD_ZXH     = 5'd2,
        CMD_TST     = 5'd3,
        CMD_AND     = 5'd4,
        CMD_NOT     = 5'd5,
        CMD_XOR     = 5'd6,
        CMD_SXH     = 5'd7,
        CMD_SXB     = 5'd8,
        CMD_SHL_IMM = 5'd9,
        CMD_SHR_IMM = 5'd10,
        CMD_SAR_IMM = 5'd11,
        CMD_ANDI    = 5'd12,
        CMD_ORI     = 5'd13,
        CMD_XORI    = 5'd14,
        CMD_SHL_REG = 5'd15,
        CMD_SHR_REG = 5'd16,
        CMD_SAR_REG = 5'd17,
        CMD_SHL_3R  = 5'd18,
        CMD_SHR_3R  = 5'd19,
        CMD_SAR_3R  = 5'd20,
        CMD_HSH     = 5'd21,
        CMD_HSW     = 5'd22,
        CMD_BSH     = 5'd23,
        CMD_BSW     = 5'd24
    } cmd_t;

    typedef struct packed {
        logic cy;
        logic ov;
        logic s;
        logic z;
    } flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              wr;
        logic              step4;
        flags_t            flags;
    } alu_res_t;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} < REG_LIMIT;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lseu_regfile.sv */
// Register file: synchronous memory, two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset value. Depends on lseu_pkg.
`default_nettype none

module lseu_regfile (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lseu_pkg::IDX_W-1:0]  rd_a_idx,
    input  wire logic [lseu_pkg::IDX_W-1:0]  rd_b_idx,
    output logic      [lseu_pkg::DATA_W-1:0] rd_a_data,
    output logic      [lseu_pkg::DATA_W-1:0] rd_b_data,
    input  wire logic                        wr_en,
    input  wire logic [lseu_pkg::IDX_W-1:0]  wr_idx,
    input  wire logic [lseu_pkg::DATA_W-1:0] wr_data
);
    import lseu_pkg::*;

    logic [DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0] a_data_reg;
    logic [DATA_W-1:0] b_data_reg;
    logic a_hit_reg;
    logic b_hit_reg;

    // memory array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[REG_AW-1:0]] <= wr_data;
        end
        a_data_reg <= mem[rd_a_idx[REG_AW-1:0]];
        b_data_reg <= mem[rd_b_idx[REG_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            a_hit_reg <= 1'b0;
            b_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx[REG_AW-1:0]] <= 1'b1;
            end
            a_hit_reg <= in_range(rd_a_idx) && valid_reg[rd_a_idx[REG_AW-1:0]];
            b_hit_reg <= in_range(rd_b_idx) && valid_reg[rd_b_idx[REG_AW-1:0]];
        end
    end

    assign rd_a_data = a_hit_reg ? a_data_reg : '0;
    assign rd_b_data = b_hit_reg ? b_data_reg : '0;

endmodule

`default_nettype wire

/* hw/rtl/lseu_alu.sv */
// Combinational datapath: logic ops, extensions, barrel shifts, swaps, flags.
// Depends on lseu_pkg.
`default_nettype none

module lseu_alu (
    input  wire logic [4:0]                  cmd,
    input  wire logic [lseu_pkg::IDX_W-1:0]  first_index,
    input  wire logic [lseu_pkg::IDX_W-1:0]  second_index,
    input  wire logic [lseu_pkg::IDX_W-1:0]  third_index,
    input  wire logic [15:0]                 immediate,
    input  wire logic [lseu_pkg::DATA_W-1:0] a,
    input  wire logic [lseu_pkg::DATA_W-1:0] b,
    input  wire lseu_pkg::flags_t            flags_in,
    output lseu_pkg::alu_res_t               res
);
    import lseu_pkg::*;

    function automatic flags_t zs_flags(input logic [DATA_W-1:0] v, input logic cy);
        flags_t f;
        f.cy = cy;
        f.ov = 1'b0;
        f.s  = v[DATA_W-1];
        f.z  = (v == '0);
        return f;
    endfunction

    logic [4:0]         sh_cnt;
    logic [DATA_W:0]    shl_w;
    logic [DATA_W:0]    shr_w;
    logic [DATA_W:0]    sar_w;
    logic signed [DATA_W:0] sar_src;
    logic [DATA_W-1:0]  ext_imm;
    logic [DATA_W-1:0]  hsw_v;
    logic [DATA_W-1:0]  bsh_v;
    logic [DATA_W-1:0]  bsw_v;
    cmd_t               op;

    assign op      = cmd_t'(cmd);
    assign ext_imm = {16'h0000, immediate};
    assign sh_cnt  = (op == CMD_SHL_IMM || op == CMD_SHR_IMM || op == CMD_SAR_IMM)
                     ? immediate[4:0] : a[4:0];

    // carry sits in the extra bit: top bit for left, bit 0 for right
    assign shl_w   = {1'b0, b} << sh_cnt;
    assign shr_w   = {b, 1'b0} >> sh_cnt;
    assign sar_src = {b, 1'b0};
    assign sar_w   = sar_src >>> sh_cnt;

    assign hsw_v = {b[15:0], b[31:16]};
    assign bsh_v = {b[23:16], b[31:24], b[7:0], b[15:8]};
    assign bsw_v = {b[7:0], b[15:8], b[23:16], b[31:24]};

    always_comb
    begin
        res.value = '0;
        res.index = '0;
        res.wr    = 1'b0;
        res.step4 = 1'b0;
        res.flags = flags_in;
        case (op)
            CMD_OR:
            begin
                res.value = b | a;
                res.index = second_index;
                res.wr    = 1'b1;
                res.flags = zs_flags(b | a, flags_in.cy);
            end
            CMD_ZXB:
            begin
                res.value = {24'h000000, a[7:0]};
                res.index = first_index;
                res.wr    = 1'b1;
            end
            CMD_ZXH:
            begin
                res.value = {16'h0000, a[15:0]};
                res.index = first_index;
                res.wr    = 1'b1;
            end
            CMD_TST:
            begin
                res.flags = zs_flags(b & a, flags_in.cy);
            end
            CMD_AND:
            begin
                res.value = b & a;
                res.index = second_index;
                res.wr    = 1'b1;
                res.flags = zs_flags(b & a, flags_in.cy);
            end
            CMD_NOT:
            begin
                res.value = ~a;
                res.index = second_index;
                res.wr    = 1'b1;
                res.flags = zs_flags(~a, flags_in.cy);
            end
            CMD_XOR:
            begin
                res.value = b ^ a;
                res.index = second_index;
                res.wr    = 1'b1;
                res.flags = zs_flags(b ^ a, flags_in.cy);
            end
            CMD_SXH:
            begin
                res.value = {{16{a[15]}}, a[15:0]};
                res.index = first_index;
                res.wr    = 1'b1;
            end
            CMD_SXB:
            begin
                res.value = {{24{a[7]}}, a[7:0]};
                res.index = first_index;
                res.wr    = 1'b1;
            end
            CMD_SHL_IMM, CMD_SHL_REG, CMD_SHL_3R:
            begin
                res.value = shl_w[DATA_W-1:0];
                res.flags = zs_flags(shl_w[DATA_W-1:0], shl_w[DATA_W]);
            end
            CMD_SHR_IMM, CMD_SHR_REG, CMD_SHR_3R:
            begin
                res.value = shr_w[DATA_W:1];
                res.flags = zs_flags(shr_w[DATA_W:1], shr_w[0]);
            end
            CMD_SAR_IMM, CMD_SAR_REG, CMD_SAR_3R:
            begin
                res.value = sar_w[DATA_W:1];
                res.flags = zs_flags(sar_w[DATA_W:1], sar_w[0]);
            end
            CMD_ANDI:
            begin
                res.value = a & ext_imm;
                res.flags = zs_flags(a & ext_imm, flags_in.cy);
            end
            CMD_ORI:
            begin
                res.value = a | ext_imm;
                res.flags = zs_flags(a | ext_imm, flags_in.cy);
            end
            CMD_XORI:
            begin
                res.value = a ^ ext_imm;
                res.flags = zs_flags(a ^ ext_imm, flags_in.cy);
            end
            CMD_HSH:
            begin
                res.value    = b;
                res.flags.cy = (b[15:0] == 16'h0000);
                res.flags.z  = (b[15:0] == 16'h0000);
                res.flags.s  = b[31];
                res.flags.ov = 1'b0;
            end
            CMD_HSW:
            begin
                res.value = hsw_v;
                res.flags = zs_flags(hsw_v,
                                     hsw_v[15:0] == 16'h0000 || hsw_v[31:16] == 16'h0000);
            end
            CMD_BSH:
            begin
                res.value    = bsh_v;
                res.flags.cy = (bsh_v[7:0] == 8'h00) || (bsh_v[15:8] == 8'h00);
                res.flags.z  = (bsh_v[15:0] == 16'h0000);
                res.flags.s  = bsh_v[31];
                res.flags.ov = 1'b0;
            end
            CMD_BSW:
            begin
                res.value = bsw_v;
                res.flags = zs_flags(bsw_v,
                                     bsw_v[7:0] == 8'h00 || bsw_v[15:8] == 8'h00 ||
                                     bsw_v[23:16] == 8'h00 || bsw_v[31:24] == 8'h00);
            end
            default:
            begin
                res.value = '0;
            end
        endcase

        // destination and format for the grouped forms
        case (op)
            CMD_SHL_IMM, CMD_SHR_IMM, CMD_SAR_IMM:
            begin
                res.index = second_index;
                res.wr    = 1'b1;
            end
            CMD_ANDI, CMD_ORI, CMD_XORI, CMD_SHL_REG, CMD_SHR_REG, CMD_SAR_REG:
            begin
                res.index = second_index;
                res.wr    = 1'b1;
                res.step4 = 1'b1;
            end
            CMD_SHL_3R, CMD_SHR_3R, CMD_SAR_3R, CMD_HSH, CMD_HSW, CMD_BSH, CMD_BSW:
            begin
                res.index = third_index;
                res.wr    = 1'b1;
                res.step4 = 1'b1;
            end
            default:
            begin
                res.step4 = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/logic_shift_execute_unit.sv */
// Top level of the logic/shift execute unit: control, flags, PC, result register.
// Depends on lseu_pkg, lseu_regfile and lseu_alu.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one decoded instruction per
//   transaction: cmd, first_index, second_index, third_index, immediate.
//   Output channel (out_valid / out_stall) returns exactly one transaction per
//   input: write_value, write_enable, write_index, the four flags and next_pc.
//   Timing: the register file is a synchronous memory with registered reads.
//   The cycle of acceptance issues both operand reads; the next cycle computes
//   and, unless the result register is held, writes the destination back and
//   loads the result register, whose outputs then show the result. The unit
//   takes no new transaction while one is in the execute slot. in_stall stays
//   high while an instruction is between read and write-back, so no two
//   accesses to the same register overlap.
//   Receiver stall: the result register holds while out_stall is high; a second
//   instruction may then wait in the execute slot, re-reading its operands each
//   cycle, and in_stall stays high until the result register frees up.
//   Reset (rst_n low, asynchronous): flags and PC clear, all registers read as
//   zero through per-entry valid bits; no clearing pass, ready right away.
`default_nettype none

module logic_shift_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  cmd,
    input  wire logic [4:0]  first_index,
    input  wire logic [4:0]  second_index,
    input  wire logic [4:0]  third_index,
    input  wire logic [15:0] immediate,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      write_value,
    output logic             write_enable,
    output logic [4:0]       write_index,
    output logic             flag_carry,
    output logic             flag_overflow,
    output logic             flag_sign,
    output logic             flag_zero,
    output logic [31:0]      next_pc
);
    import lseu_pkg::*;

    // execute slot: instruction whose operands are being read
    logic              ex_valid_reg;
    logic [4:0]        ex_cmd_reg;
    logic [IDX_W-1:0]  ex_first_reg;
    logic [IDX_W-1:0]  ex_second_reg;
    logic [IDX_W-1:0]  ex_third_reg;
    logic [15:0]       ex_imm_reg;

    // architectural state outside the memory
    flags_t            flags_reg;
    logic [DATA_W-1:0] pc_reg;
    logic [DATA_W-1:0] pc_next;

    // result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_we_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    flags_t            out_flags_reg;
    logic [DATA_W-1:0] out_pc_reg;

    logic              accept;
    logic              retire;
    logic              rf_we;
    logic [IDX_W-1:0]  rd_a_idx;
    logic [IDX_W-1:0]  rd_b_idx;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    alu_res_t          alu_res;

    assign in_stall = ex_valid_reg;
    assign accept   = in_valid && !ex_valid_reg;
    // result register is free or being emptied this cycle
    assign retire   = ex_valid_reg && (!out_valid_reg || !out_stall);

    // a waiting instruction keeps its own read addresses
    assign rd_a_idx = ex_valid_reg ? ex_first_reg  : first_index;
    assign rd_b_idx = ex_valid_reg ? ex_second_reg : second_index;

    assign rf_we   = retire && alu_res.wr && in_range(alu_res.index);
    assign pc_next = pc_reg + {29'd0, alu_res.step4, !alu_res.step4, 1'b0};

    lseu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_idx  (rd_a_idx),
        .rd_b_idx  (rd_b_idx),
        .rd_a_data (op_a),
        .rd_b_data (op_b),
        .wr_en     (rf_we),
        .wr_idx    (alu_res.index),
        .wr_data   (alu_res.value)
    );

    lseu_alu u_alu (
        .cmd          (ex_cmd_reg),
        .first_index  (ex_first_reg),
        .second_index (ex_second_reg),
        .third_index  (ex_third_reg),
        .immediate    (ex_imm_reg),
        .a            (op_a),
        .b            (op_b),
        .flags_in     (flags_reg),
        .res          (alu_res)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                ex_valid_reg <= 1'b0;
            end

            if (retire)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_res.flags;
                pc_reg        <= pc_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_cmd_reg    <= cmd;
            ex_first_reg  <= first_index;
            ex_second_reg <= second_index;
            ex_third_reg  <= third_index;
            ex_imm_reg    <= immediate;
        end
        if (retire)
        begin
            out_value_reg <= alu_res.value;
            out_we_reg    <= rf_we;
            out_idx_reg   <= alu_res.index;
            out_flags_reg <= alu_res.flags;
            out_pc_reg    <= pc_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_value   = out_value_reg;
    assign write_enable  = out_we_reg;
    assign write_index   = out_idx_reg;
    assign flag_carry    = out_flags_reg.cy;
    assign flag_overflow = out_flags_reg.ov;
    assign flag_sign     = out_flags_reg.s;
    assign flag_zero     = out_flags_reg.z;
    assign next_pc       = out_pc_reg;

endmodule

`default_nettype wire

/* hw/rtl/lseu_checker.sv */
// Port-level checks for logic_shift_execute_unit, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lseu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] write_value,
    input wire logic [31:0] next_pc
);

    logic        in_acc;
    logic        out_blocked;
    logic [63:0] out_payload;

    assign in_acc      = in_valid && !in_stall;
    assign out_blocked = out_valid && out_stall;
    assign out_payload = {write_value, next_pc};

    // one instruction in flight between operand read and write-back
    `LSEU_ASSERT(a_busy_after_accept, clk, rst_n, in_acc |=> in_stall)

    // result appears as soon as the result register is free
    `LSEU_ASSERT(a_result_follows, clk, rst_n, in_acc ##1 !out_blocked |=> out_valid)

    // stalled result holds
    `LSEU_ASSERT(a_out_hold, clk, rst_n, out_blocked |=> out_valid && $stable(out_payload))

    // PC advances from zero in steps of 2 or 4
    `LSEU_ASSERT_MSG(a_pc_even, clk, rst_n, out_valid |-> !next_pc[0], "odd next_pc")

endmodule

bind logic_shift_execute_unit lseu_checker u_lseu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .write_value (write_value),
    .next_pc     (next_pc)
);

`default_nettype wire
